// ----- rtl/ftcd_pkg.sv -----
// Package with the microcode table, codes and calendar helpers for the FILETIME date converter.
package ftcd_pkg;

  localparam int TS_W       = 64;
  localparam int REM_W      = 24;
  localparam int DIG_W      = 8;
  localparam int ACC_W      = REM_W + DIG_W;
  localparam int RCP_W      = 28;
  localparam int DAY_W      = 25;
  localparam int STEP_W     = 3;
  localparam int CNT_W      = 4;
  localparam int YEAR_OUT_W = 14;

  localparam int MAX_YEAR_DEF = 9999;
  localparam int FIRST_YEAR   = 1601;

  localparam logic [REM_W-1:0] TICKS_PER_SEC = REM_W'(10000000);
  localparam logic [REM_W-1:0] SIXTY         = REM_W'(60);
  localparam logic [REM_W-1:0] HOURS_PER_DAY = REM_W'(24);

  // Each reciprocal is two to the power ACC_W over its divisor, rounded down.
  localparam logic [RCP_W-1:0] RCP_TICK = RCP_W'((64'd1 << ACC_W) / 64'd10000000);
  localparam logic [RCP_W-1:0] RCP_60   = RCP_W'((64'd1 << ACC_W) / 64'd60);
  localparam logic [RCP_W-1:0] RCP_24   = RCP_W'((64'd1 << ACC_W) / 64'd24);

  // Micro-operations.
  localparam logic [2:0] OP_DIV   = 3'd0;
  localparam logic [2:0] OP_INIT  = 3'd1;
  localparam logic [2:0] OP_YEAR  = 3'd2;
  localparam logic [2:0] OP_MONTH = 3'd3;
  localparam logic [2:0] OP_DONE  = 3'd4;

  // Divisor selects.
  localparam logic [1:0] DSEL_TICK = 2'd0;
  localparam logic [1:0] DSEL_60   = 2'd1;
  localparam logic [1:0] DSEL_24   = 2'd2;

  // Remainder destinations.
  localparam logic [1:0] DST_NONE = 2'd0;
  localparam logic [1:0] DST_SEC  = 2'd1;
  localparam logic [1:0] DST_MIN  = 2'd2;
  localparam logic [1:0] DST_HR   = 2'd3;

  // Program steps.
  localparam logic [STEP_W-1:0] STEP_TICKS = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SECS  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MINS  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_HRS   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_INIT  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_YEAR  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_MONTH = 3'd6;
  localparam logic [STEP_W-1:0] STEP_DONE  = 3'd7;

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        dsel;
    logic [1:0]        dst;
    logic [STEP_W-1:0] nxt;
    logic [STEP_W-1:0] alt;
  } ctl_word_t;

  function automatic ctl_word_t ctl_rom(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    w = '0;
    unique case (step)
      STEP_TICKS: w = '{OP_DIV,   DSEL_TICK, DST_NONE, STEP_SECS,  STEP_SECS};
      STEP_SECS:  w = '{OP_DIV,   DSEL_60,   DST_SEC,  STEP_MINS,  STEP_MINS};
      STEP_MINS:  w = '{OP_DIV,   DSEL_60,   DST_MIN,  STEP_HRS,   STEP_HRS};
      STEP_HRS:   w = '{OP_DIV,   DSEL_24,   DST_HR,   STEP_INIT,  STEP_INIT};
      STEP_INIT:  w = '{OP_INIT,  DSEL_TICK, DST_NONE, STEP_YEAR,  STEP_YEAR};
      STEP_YEAR:  w = '{OP_YEAR,  DSEL_TICK, DST_NONE, STEP_MONTH, STEP_DONE};
      STEP_MONTH: w = '{OP_MONTH, DSEL_TICK, DST_NONE, STEP_DONE,  STEP_DONE};
      STEP_DONE:  w = '{OP_DONE,  DSEL_TICK, DST_NONE, STEP_TICKS, STEP_TICKS};
      default:    w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [REM_W-1:0] divisor(input logic [1:0] dsel);
    logic [REM_W-1:0] d;
    d = TICKS_PER_SEC;
    unique case (dsel)
      DSEL_TICK: d = TICKS_PER_SEC;
      DSEL_60:   d = SIXTY;
      DSEL_24:   d = HOURS_PER_DAY;
      default:   d = TICKS_PER_SEC;
    endcase
    return d;
  endfunction

  function automatic logic [RCP_W-1:0] recip(input logic [1:0] dsel);
    logic [RCP_W-1:0] r;
    r = RCP_TICK;
    unique case (dsel)
      DSEL_TICK: r = RCP_TICK;
      DSEL_60:   r = RCP_60;
      DSEL_24:   r = RCP_24;
      default:   r = RCP_TICK;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    case (m) inside
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/filetime_to_calendar_date.sv -----
// Converts a FILETIME tick count into a Gregorian date and time of day.
//
// Pulse start for one cycle while busy is low; in_timestamp is taken at that
// edge. The block then raises busy and runs a short microprogram: four
// divisions by constants (ten million, 60, 60 and 24) that take the dividend
// a byte at a time, estimating each quotient byte by a reciprocal multiply and
// correcting it in the next cycle; one setup step; a year walk that tests one
// year per cycle; a month walk that tests one month per cycle, skipped when
// the date lies beyond the maximum year; and a finish step. The result
// appears on the out_ ports for exactly one cycle with out_valid high, at the
// same edge that busy falls, so the next start may follow at once; a new word
// is taken only once the result of the last has been shown. The receiver
// cannot stall the block. When the date lies beyond the maximum year,
// out_year_error is high and year, month and day read zero; hour, minute and
// second stay valid. Reset clears busy and out_valid; no item is in flight
// after reset.
module filetime_to_calendar_date
  import ftcd_pkg::*;
#(
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [TS_W-1:0]       in_timestamp,
  output logic                  out_valid,
  output logic [YEAR_OUT_W-1:0] out_year,
  output logic [3:0]            out_month,
  output logic [4:0]            out_day,
  output logic [4:0]            out_hour,
  output logic [5:0]            out_minute,
  output logic [5:0]            out_second,
  output logic                  out_year_error
);

  localparam int YW = $clog2(MAX_YEAR + 2);

  logic                  busy_r, busy_nxt;
  logic [STEP_W-1:0]     pc_r, pc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TS_W-1:0]       dvd_r, dvd_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [DIG_W-1:0]      est_r, est_nxt;
  logic [DAY_W-1:0]      days_r, days_nxt;
  logic [YW-1:0]         year_r, year_nxt;
  logic [6:0]            c100_r, c100_nxt;
  logic [1:0]            q4_r, q4_nxt;
  logic [3:0]            month_r, month_nxt;
  logic [5:0]            sec_r, sec_nxt;
  logic [5:0]            min_r, min_nxt;
  logic [4:0]            hr_r, hr_nxt;
  logic                  err_r, err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [YEAR_OUT_W-1:0] out_year_r, out_year_nxt;
  logic [3:0]            out_month_r, out_month_nxt;
  logic [4:0]            out_day_r, out_day_nxt;
  logic [4:0]            out_hour_r, out_hour_nxt;
  logic [5:0]            out_minute_r, out_minute_nxt;
  logic [5:0]            out_second_r, out_second_nxt;
  logic                  out_err_r, out_err_nxt;

  ctl_word_t              cw;
  logic [REM_W-1:0]       dv;
  logic [RCP_W-1:0]       rcp;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W+RCP_W-1:0] est_prod;
  logic [ACC_W-1:0]       prod;
  logic [ACC_W-1:0]       diff;
  logic                   fix;
  logic [REM_W-1:0]       rem_fix;
  logic [DIG_W-1:0]       digit;
  logic                   leap;
  logic [8:0]             ylen;
  logic [4:0]             mlen;
  logic [YW:0]            year_inc;

  assign cw       = ctl_rom(pc_r);
  assign dv       = divisor(cw.dsel);
  assign rcp      = recip(cw.dsel);
  assign acc      = {rem_r, dvd_r[TS_W-1 -: DIG_W]};
  assign est_prod = (ACC_W+RCP_W)'(acc) * (ACC_W+RCP_W)'(rcp);
  assign prod     = ACC_W'(est_r) * ACC_W'(dv);
  assign diff     = acc - prod;
  assign fix      = diff >= ACC_W'(dv);
  assign rem_fix  = fix ? REM_W'(diff - ACC_W'(dv)) : REM_W'(diff);
  assign digit    = est_r + DIG_W'(fix);

  assign leap     = ((year_r[1:0] == 2'd0) && (c100_r != 7'd0)) ||
                    ((c100_r == 7'd0) && (q4_r == 2'd0));
  assign ylen     = leap ? 9'd366 : 9'd365;
  assign mlen     = month_len(month_r, leap);
  assign year_inc = {1'b0, year_r} + (YW+1)'(1);

  always_comb begin
    busy_nxt       = busy_r;
    pc_nxt         = pc_r;
    cnt_nxt        = cnt_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    est_nxt        = est_r;
    days_nxt       = days_r;
    year_nxt       = year_r;
    c100_nxt       = c100_r;
    q4_nxt         = q4_r;
    month_nxt      = month_r;
    sec_nxt        = sec_r;
    min_nxt        = min_r;
    hr_nxt         = hr_r;
    err_nxt        = err_r;
    out_valid_nxt  = 1'b0;
    out_year_nxt   = out_year_r;
    out_month_nxt  = out_month_r;
    out_day_nxt    = out_day_r;
    out_hour_nxt   = out_hour_r;
    out_minute_nxt = out_minute_r;
    out_second_nxt = out_second_r;
    out_err_nxt    = out_err_r;

    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = STEP_TICKS;
        cnt_nxt  = '0;
        dvd_nxt  = in_timestamp;
        rem_nxt  = '0;
        err_nxt  = 1'b0;
      end
    end else begin
      unique case (cw.op)
        OP_DIV: begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (!cnt_r[0]) begin
            est_nxt = est_prod[ACC_W +: DIG_W];
          end else begin
            dvd_nxt = {dvd_r[TS_W-DIG_W-1:0], digit};
            rem_nxt = rem_fix;
            if (cnt_r == '1) begin
              rem_nxt = '0;
              pc_nxt  = cw.nxt;
              unique case (cw.dst)
                DST_NONE: ;
                DST_SEC:  sec_nxt = rem_fix[5:0];
                DST_MIN:  min_nxt = rem_fix[5:0];
                DST_HR:   hr_nxt  = rem_fix[4:0];
                default:  ;
              endcase
            end
          end
        end
        OP_INIT: begin
          days_nxt  = dvd_r[DAY_W-1:0] + DAY_W'(1);
          year_nxt  = YW'(FIRST_YEAR);
          c100_nxt  = 7'(FIRST_YEAR % 100);
          q4_nxt    = 2'((FIRST_YEAR / 100) % 4);
          month_nxt = 4'd1;
          pc_nxt    = cw.nxt;
        end
        OP_YEAR: begin
          if (days_r <= DAY_W'(ylen)) begin
            pc_nxt = cw.nxt;
          end else begin
            days_nxt = days_r - DAY_W'(ylen);
            if (year_inc > (YW+1)'(MAX_YEAR)) begin
              err_nxt = 1'b1;
              pc_nxt  = cw.alt;
            end else begin
              year_nxt = year_inc[YW-1:0];
              if (c100_r == 7'd99) begin
                c100_nxt = '0;
                q4_nxt   = q4_r + 2'd1;
              end else begin
                c100_nxt = c100_r + 7'd1;
              end
            end
          end
        end
        OP_MONTH: begin
          if ((month_r == 4'd12) || (days_r <= DAY_W'(mlen))) begin
            pc_nxt = cw.nxt;
          end else begin
            days_nxt  = days_r - DAY_W'(mlen);
            month_nxt = month_r + 4'd1;
          end
        end
        OP_DONE: begin
          busy_nxt       = 1'b0;
          pc_nxt         = cw.nxt;
          out_valid_nxt  = 1'b1;
          out_year_nxt   = err_r ? '0 : YEAR_OUT_W'(year_r);
          out_month_nxt  = err_r ? '0 : month_r;
          out_day_nxt    = err_r ? '0 : days_r[4:0];
          out_hour_nxt   = hr_r;
          out_minute_nxt = min_r;
          out_second_nxt = sec_r;
          out_err_nxt    = err_r;
        end
        default: begin
          busy_nxt = 1'b0;
          pc_nxt   = STEP_TICKS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= STEP_TICKS;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    est_r        <= est_nxt;
    days_r       <= days_nxt;
    year_r       <= year_nxt;
    c100_r       <= c100_nxt;
    q4_r         <= q4_nxt;
    month_r      <= month_nxt;
    sec_r        <= sec_nxt;
    min_r        <= min_nxt;
    hr_r         <= hr_nxt;
    out_year_r   <= out_year_nxt;
    out_month_r  <= out_month_nxt;
    out_day_r    <= out_day_nxt;
    out_hour_r   <= out_hour_nxt;
    out_minute_r <= out_minute_nxt;
    out_second_r <= out_second_nxt;
    out_err_r    <= out_err_nxt;
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_year       = out_year_r;
  assign out_month      = out_month_r;
  assign out_day        = out_day_r;
  assign out_hour       = out_hour_r;
  assign out_minute     = out_minute_r;
  assign out_second     = out_second_r;
  assign out_year_error = out_err_r;

`ifndef SYNTHESIS
  // A result word is only shown once the sequencer has returned to idle.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r)
    else $error("result strobe while busy");

  // An accepted word starts the program at its first step.
  a_start_step: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> (busy_r && pc_r == STEP_TICKS && cnt_r == '0))
    else $error("program did not start at first step");

  // The year walk never runs past the supported maximum.
  a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && pc_r == STEP_YEAR) |-> (year_r <= YW'(MAX_YEAR)))
    else $error("year walk beyond maximum");

  // A valid date always has a month from 1 to 12 and a nonzero day.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_err_r) |->
      (out_month_r >= 4'd1 && out_month_r <= 4'd12 && out_day_r != 5'd0))
    else $error("date fields out of range");
`endif

endmodule

// ----- tb/filetime_to_calendar_date_tb.sv -----
// Self-checking testbench for the FILETIME to calendar date converter.
module filetime_to_calendar_date_tb
  import ftcd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LAST_YEAR = MAX_YEAR_DEF;
  localparam bit [63:0] TICKS_PER_SECOND = 64'd10_000_000;
  localparam bit [63:0] TICKS_PER_DAY = 64'd864_000_000_000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [YEAR_OUT_W-1:0] year;
    logic [3:0]            month;
    logic [4:0]            day;
    logic [4:0]            hour;
    logic [5:0]            minute;
    logic [5:0]            second;
    logic                  year_error;
  } date_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [TS_W-1:0]       in_timestamp;
  logic                  out_valid;
  logic [YEAR_OUT_W-1:0] out_year;
  logic [3:0]            out_month;
  logic [4:0]            out_day;
  logic [4:0]            out_hour;
  logic [5:0]            out_minute;
  logic [5:0]            out_second;
  logic                  out_year_error;

  date_t       pending_dates[$];
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned dates_checked;
  int unsigned overflow_dates;
  int unsigned leap_days_seen;
  bit [63:0]   last_valid_tick;

  filetime_to_calendar_date dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_timestamp  (in_timestamp),
    .out_valid     (out_valid),
    .out_year      (out_year),
    .out_month     (out_month),
    .out_day       (out_day),
    .out_hour      (out_hour),
    .out_minute    (out_minute),
    .out_second    (out_second),
    .out_year_error(out_year_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(100_000_000);
    $display("Timeout with %0d dates still outstanding.", pending_dates.size());
    $display("FAILURE");
    $finish;
  end

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    if (m == 2) begin
      return is_leap(y) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic bit [63:0] tick_of(input int unsigned y, input int unsigned mo,
                                        input int unsigned d, input int unsigned h,
                                        input int unsigned mi, input int unsigned s,
                                        input bit [63:0] frac);
    bit [63:0] days;
    days = 0;
    for (int unsigned yy = FIRST_YEAR; yy < y; yy++) begin
      days += is_leap(yy) ? 366 : 365;
    end
    for (int unsigned m = 1; m < mo; m++) begin
      days += month_days(m, y);
    end
    days += d - 1;
    return (((days * 24 + h) * 60 + mi) * 60 + s) * TICKS_PER_SECOND + frac;
  endfunction

  function automatic date_t calendar_of(input bit [63:0] ts);
    bit [63:0]   secs;
    bit [63:0]   days;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    date_t       r;
    r = '0;
    secs = ts / TICKS_PER_SECOND;
    r.second = 6'(secs % 60);
    secs = secs / 60;
    r.minute = 6'(secs % 60);
    secs = secs / 60;
    r.hour = 5'(secs % 24);
    days = secs / 24 + 1;
    y = FIRST_YEAR;
    m = 1;
    while (1) begin
      len = is_leap(y) ? 366 : 365;
      if (days <= len) break;
      days -= len;
      y++;
      if (y > LAST_YEAR) begin
        r.year_error = 1'b1;
        break;
      end
    end
    if (!r.year_error) begin
      while (m < 12 && days > month_days(m, y)) begin
        days -= month_days(m, y);
        m++;
      end
      r.year = YEAR_OUT_W'(y);
      r.month = 4'(m);
      r.day = 5'(days);
    end
    return r;
  endfunction

  function automatic bit [63:0] random_word64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    date_t exp_date;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected date at %0t: %0d-%0d-%0d %0d:%0d:%0d err=%0b", $realtime,
                   out_year, out_month, out_day, out_hour, out_minute, out_second,
                   out_year_error);
        end
      end else begin
        exp_date = pending_dates.pop_front();
        dates_checked++;
        if (exp_date.year_error) overflow_dates++;
        if (exp_date.month == 2 && exp_date.day == 29) leap_days_seen++;
        if (out_year !== exp_date.year || out_month !== exp_date.month ||
            out_day !== exp_date.day || out_hour !== exp_date.hour ||
            out_minute !== exp_date.minute || out_second !== exp_date.second ||
            out_year_error !== exp_date.year_error) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch at %0t: expected %0d-%0d-%0d %0d:%0d:%0d err=%0b,",
                     $realtime, exp_date.year, exp_date.month, exp_date.day,
                     exp_date.hour, exp_date.minute, exp_date.second, exp_date.year_error);
            $display("  got %0d-%0d-%0d %0d:%0d:%0d err=%0b",
                     out_year, out_month, out_day, out_hour, out_minute, out_second,
                     out_year_error);
          end
        end
      end
    end
  end

  // Start stays high between back-to-back words so it is never lowered and raised in one step.
  task automatic send_word(input bit [63:0] ts, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_timestamp <= ts;
    do @(posedge clk); while (busy !== 1'b0);
    pending_dates.push_back(calendar_of(ts));
    words_sent++;
  endtask

  task automatic test_time_of_day_extremes();
    send_word(64'd0, 1'b0);
    send_word(TICKS_PER_SECOND - 1, 1'b0);
    send_word(tick_of(1601, 12, 31, 23, 59, 59, 64'd9_999_999), 1'b0);
    send_word(tick_of(2024, 1, 31, 12, 0, 0, 64'd0), 1'b0);
    send_word(tick_of(2024, 11, 30, 23, 59, 59, 64'd0), 1'b0);
  endtask

  task automatic test_leap_rules();
    send_word(tick_of(1604, 2, 29, 12, 34, 56, 64'd0), 1'b0);
    send_word(tick_of(1604, 12, 31, 0, 0, 0, 64'd0), 1'b0);
    send_word(tick_of(1700, 2, 28, 23, 59, 59, 64'd0), 1'b0);
    send_word(tick_of(1700, 3, 1, 0, 0, 0, 64'd0), 1'b0);
    send_word(tick_of(1900, 3, 1, 6, 7, 8, 64'd0), 1'b0);
    send_word(tick_of(2000, 2, 29, 23, 59, 59, 64'd0), 1'b0);
    send_word(tick_of(2000, 12, 31, 23, 59, 59, 64'd0), 1'b0);
  endtask

  task automatic test_year_limit();
    send_word(last_valid_tick, 1'b0);
    send_word(last_valid_tick + 1, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b0);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_word(64'h5555_5555_5555_5555, 1'b0);
  endtask

  task automatic test_random_timestamps(input int unsigned count);
    bit [63:0]   ts;
    bit [63:0]   base;
    bit          burst;
    int unsigned kind;
    burst = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 10 == 0) burst = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        ts = 64'($urandom_range(0, 30 * 366)) * TICKS_PER_DAY + random_word64() % TICKS_PER_DAY;
      end else if (kind <= 6) begin
        ts = random_word64() % (last_valid_tick + 1);
      end else if (kind == 7) begin
        base = tick_of($urandom_range(1602, 10000), $urandom_range(1, 12), 1, 0, 0, 0, 64'd0);
        if ($urandom_range(0, 1) != 0) begin
          ts = base - 1 - $urandom_range(0, 9_999_999);
        end else begin
          ts = base + $urandom_range(0, 9_999_999);
        end
      end else begin
        ts = random_word64();
      end
      send_word(ts, burst);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_timestamp <= '0;
    mismatches = 0;
    words_sent = 0;
    dates_checked = 0;
    overflow_dates = 0;
    leap_days_seen = 0;
    last_valid_tick = tick_of(LAST_YEAR, 12, 31, 23, 59, 59, 64'd9_999_999);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_time_of_day_extremes();
    test_leap_rules();
    test_year_limit();
    test_random_timestamps(100);

    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d timestamps and checked %0d dates.", words_sent, dates_checked);
    $display("Dates past the last year: %0d, leap days: %0d, mismatches: %0d.",
             overflow_dates, leap_days_seen, mismatches);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filetime_to_calendar_date.f -----
rtl/ftcd_pkg.sv
rtl/filetime_to_calendar_date.sv
tb/filetime_to_calendar_date_tb.sv
